// ===== hw/rtl/bct_pkg.sv =====
// Package for the box corner transform block: number format, port widths,
// register map and the fixed-point helpers. Used by every file of the block.
package bct_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int QUOT_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = COORD_WIDTH + 2;

    localparam int IN_FIELDS  = 12;
    localparam int OUT_FIELDS = 6;
    localparam int S_DATA_W   = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W   = ((OUT_FIELDS * COORD_WIDTH + 7) / 8) * 8;

    localparam int REG_COUNT = 6;
    localparam int APB_DW    = (COORD_WIDTH > 32) ? 64 : 32;
    localparam int STRIDE_W  = (COORD_WIDTH > 32) ? 3 : 2;
    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam int ADDR_W    = IDX_W + STRIDE_W;

    localparam logic [IDX_W-1:0] REG_BOX_MIN_X = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_BOX_MIN_Y = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BOX_MIN_Z = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BOX_MAX_X = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_BOX_MAX_Y = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_BOX_MAX_Z = IDX_W'(5);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Floor of the product over 2^FRAC_BITS, saturated to the coordinate range.
    function automatic coord_t fx_floor_sat(input prod_t p);
        logic signed [QUOT_W-1:0] q;
        logic                     fits;
        q    = p[PROD_W-1:FRAC_BITS];
        fits = (&q[QUOT_W-1:COORD_WIDTH-1]) || !(|q[QUOT_W-1:COORD_WIDTH-1]);
        if (fits) begin
            return q[COORD_WIDTH-1:0];
        end
        return q[QUOT_W-1] ? COORD_MIN : COORD_MAX;
    endfunction

    // Exact four-term sum, saturated once to the coordinate range.
    function automatic coord_t sat_sum4(input coord_t a, input coord_t b,
                                        input coord_t c, input coord_t d);
        logic signed [SUM_W-1:0] s;
        logic                    fits;
        s    = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
        fits = (&s[SUM_W-1:COORD_WIDTH-1]) || !(|s[SUM_W-1:COORD_WIDTH-1]);
        if (fits) begin
            return s[COORD_WIDTH-1:0];
        end
        return s[SUM_W-1] ? COORD_MIN : COORD_MAX;
    endfunction

    function automatic coord_t cmin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t cmax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hw/rtl/bct_axis.sv =====
// One world axis of the box transform: registered products of the box bounds
// with one matrix column, then floor, saturation, min/max and the saturated sum.
// Depends on bct_pkg.
module bct_axis (
    input  logic            aclk,
    input  logic            load,
    input  bct_pkg::coord_t box_lo [3],
    input  bct_pkg::coord_t box_hi [3],
    input  bct_pkg::coord_t col [3],
    input  bct_pkg::coord_t shift,
    output bct_pkg::coord_t world_lo,
    output bct_pkg::coord_t world_hi
);

    bct_pkg::prod_t  lo_prod_reg [3];
    bct_pkg::prod_t  hi_prod_reg [3];
    bct_pkg::coord_t shift_reg;
    bct_pkg::coord_t term_lo [3];
    bct_pkg::coord_t term_hi [3];

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int j = 0; j < 3; j++) begin
                lo_prod_reg[j] <= bct_pkg::PROD_W'(box_lo[j]) * bct_pkg::PROD_W'(col[j]);
                hi_prod_reg[j] <= bct_pkg::PROD_W'(box_hi[j]) * bct_pkg::PROD_W'(col[j]);
            end
            shift_reg <= shift;
        end
    end

    // Each corner picks every coordinate independently and saturation is
    // monotonic, so the extreme corner sums come from the extreme terms.
    always_comb begin
        bct_pkg::coord_t a;
        bct_pkg::coord_t b;
        for (int j = 0; j < 3; j++) begin
            a = bct_pkg::fx_floor_sat(lo_prod_reg[j]);
            b = bct_pkg::fx_floor_sat(hi_prod_reg[j]);
            term_lo[j] = bct_pkg::cmin(a, b);
            term_hi[j] = bct_pkg::cmax(a, b);
        end
    end

    assign world_lo = bct_pkg::sat_sum4(term_lo[0], term_lo[1], term_lo[2], shift_reg);
    assign world_hi = bct_pkg::sat_sum4(term_hi[0], term_hi[1], term_hi[2], shift_reg);

endmodule

// ===== hw/rtl/box_corner_transform_aabb.sv =====
// Top level of the box corner transform: APB box registers, input register,
// three axis units and the output register. Depends on bct_pkg and bct_axis.
//
//   Port group   Direction   Word contents
//   s_*          in          3x3 matrix rows then translation, one per word
//   m_*          out         world min x/y/z then world max x/y/z
//   APB          in/out      box min x/y/z, box max x/y/z at 4*index
//
// One word is accepted every cycle unless m_tready stalls a full pipeline; a result
// passes the input register, product register and output register in that order.
// The product register holds the results of the 32x32 multipliers.
// Each stage loads when it is empty or its successor moves, so bubbles close
// up under a stall. Reset is synchronous and clears the valid flags and the box registers.
module box_corner_transform_aabb (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bct_pkg::S_DATA_W-1:0]  s_tdata,  // r0c0,r0c1,r0c2,r1c0..r2c2,shift x,y,z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bct_pkg::M_DATA_W-1:0]  m_tdata,  // min x,min y,min z,max x,max y,max z
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bct_pkg::ADDR_W-1:0]    paddr,
    input  logic [bct_pkg::APB_DW-1:0]    pwdata,
    output logic [bct_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int CW = bct_pkg::COORD_WIDTH;

    bct_pkg::coord_t box_lo_reg [3];
    bct_pkg::coord_t box_hi_reg [3];
    bct_pkg::coord_t mat_reg [bct_pkg::IN_FIELDS];
    bct_pkg::coord_t out_lo_reg [3];
    bct_pkg::coord_t out_hi_reg [3];
    bct_pkg::coord_t world_lo [3];
    bct_pkg::coord_t world_hi [3];
    bct_pkg::coord_t col [3][3];
    logic            s1_valid_reg;
    logic            s2_valid_reg;
    logic            m_valid_reg;
    logic            en_out;
    logic            en2;
    logic            en1;
    logic [bct_pkg::IDX_W-1:0] reg_idx;
    logic                      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bct_pkg::ADDR_W-1:bct_pkg::STRIDE_W];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                box_lo_reg[j] <= '0;
                box_hi_reg[j] <= '0;
            end
        end else if (wr_en) begin
            case (reg_idx)
                bct_pkg::REG_BOX_MIN_X: box_lo_reg[0] <= pwdata[CW-1:0];
                bct_pkg::REG_BOX_MIN_Y: box_lo_reg[1] <= pwdata[CW-1:0];
                bct_pkg::REG_BOX_MIN_Z: box_lo_reg[2] <= pwdata[CW-1:0];
                bct_pkg::REG_BOX_MAX_X: box_hi_reg[0] <= pwdata[CW-1:0];
                bct_pkg::REG_BOX_MAX_Y: box_hi_reg[1] <= pwdata[CW-1:0];
                bct_pkg::REG_BOX_MAX_Z: box_hi_reg[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bct_pkg::REG_BOX_MIN_X: prdata = bct_pkg::APB_DW'($unsigned(box_lo_reg[0]));
            bct_pkg::REG_BOX_MIN_Y: prdata = bct_pkg::APB_DW'($unsigned(box_lo_reg[1]));
            bct_pkg::REG_BOX_MIN_Z: prdata = bct_pkg::APB_DW'($unsigned(box_lo_reg[2]));
            bct_pkg::REG_BOX_MAX_X: prdata = bct_pkg::APB_DW'($unsigned(box_hi_reg[0]));
            bct_pkg::REG_BOX_MAX_Y: prdata = bct_pkg::APB_DW'($unsigned(box_hi_reg[1]));
            bct_pkg::REG_BOX_MAX_Z: prdata = bct_pkg::APB_DW'($unsigned(box_hi_reg[2]));
            default:                prdata = '0;
        endcase
    end

    assign en_out   = !m_valid_reg || m_tready;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (en1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en_out) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            for (int i = 0; i < bct_pkg::IN_FIELDS; i++) begin
                mat_reg[i] <= s_tdata[i*CW +: CW];
            end
        end
        if (en_out && s2_valid_reg) begin
            for (int a = 0; a < 3; a++) begin
                out_lo_reg[a] <= world_lo[a];
                out_hi_reg[a] <= world_hi[a];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int j = 0; j < 3; j++) begin
                col[a][j] = mat_reg[3*j + a];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        bct_axis u_axis (
            .aclk     (aclk),
            .load     (en2 && s1_valid_reg),
            .box_lo   (box_lo_reg),
            .box_hi   (box_hi_reg),
            .col      (col[a]),
            .shift    (mat_reg[9 + a]),
            .world_lo (world_lo[a]),
            .world_hi (world_hi[a])
        );
    end

    always_comb begin
        m_tdata = '0;
        for (int a = 0; a < 3; a++) begin
            m_tdata[a*CW +: CW]       = out_lo_reg[a];
            m_tdata[(a + 3)*CW +: CW] = out_hi_reg[a];
        end
    end

endmodule

// ===== hw/rtl/bct_checker.sv =====
// Port-level checks for the box corner transform, bound to the top level.
// Depends on bct_pkg and box_corner_transform_aabb.
module bct_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bct_pkg::M_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled although the output drains");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted word gave no result within three cycles");

endmodule

bind box_corner_transform_aabb bct_checker u_bct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
